// ===== rtl/core/acc32_pkg.sv =====
// ----------------------------------------------------------------------------
// acc32_pkg: shared definitions for the 8-bit accumulator computer
// Field widths, item codes and the instruction opcode set.
// ----------------------------------------------------------------------------
package acc32_pkg;

  localparam int MEM_WORDS = 32;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 8;
  localparam int OP_W      = 2;

  // Item codes carried on the input channel. Code 3 has no meaning and
  // leaves the machine untouched.
  localparam logic [OP_W-1:0] OP_LOADMEM = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP    = 2'd2;

  // Instruction opcodes, taken from the top three bits of a memory word.
  typedef enum logic [2:0] {
    OPC_STORE  = 3'd0,
    OPC_LOAD   = 3'd1,
    OPC_BRZ    = 3'd2,
    OPC_NOP    = 3'd3,
    OPC_DEC    = 3'd4,
    OPC_INC    = 3'd5,
    OPC_JUMP   = 3'd6,
    OPC_HALT   = 3'd7
  } opcode_t;

endpackage

// ===== rtl/core/acc32_if.sv =====
// ----------------------------------------------------------------------------
// acc32 channel interfaces
// Valid/ready channels for input items and for machine state results.
// ----------------------------------------------------------------------------
interface acc32_in_if;
  import acc32_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;

  modport source (output valid, output op, output addr, output data, input ready);
  modport sink   (input valid, input op, input addr, input data, output ready);
endinterface

interface acc32_out_if;
  import acc32_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] acc_value;
  logic [ADDR_W-1:0] next_pc;
  logic              halted;

  modport source (output valid, output acc_value, output next_pc, output halted,
                  input ready);
  modport sink   (input valid, input acc_value, input next_pc, input halted,
                  output ready);
endinterface

// ===== rtl/core/acc32_ram.sv =====
// ----------------------------------------------------------------------------
// acc32_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module acc32_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/accumulator_cpu_32_byte_core.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_32_byte_core: 8-bit accumulator computer, 32-byte memory
// A small sequencer runs one input beat at a time through a shared adder
// and a 32 x 8 RAM.
// ----------------------------------------------------------------------------
// Usage:
// Input beats arrive on in_if. A load beat writes data at addr, a restart
// beat clears the accumulator, program counter and halt flag, and a step
// beat executes the instruction at the program counter. Every input beat
// produces exactly one output beat on out_if carrying the accumulator,
// program counter and halt flag after that beat.
// Load, restart, unused codes and steps while halted go from idle straight
// to done; a step passes through fetch and execute, and a step that runs
// a memory load also through an operand state, since the operand needs a
// second RAM read. The RAM's single registered read port and the shared
// adder (program counter advance, then accumulator update) set this order.
// in_if.ready is high only while the sequencer is idle, so one beat is in
// flight at a time. The result sits in an output register; when the
// receiver stalls, a new beat may still be accepted and the sequencer
// holds its finished result until the output register frees up.
// Synchronous active-low reset clears the machine registers and the
// sequencer. Memory content is not reset; programs load it first.
// ----------------------------------------------------------------------------
module accumulator_cpu_32_byte_core (
  input  logic             clk,
  input  logic             rst_n,
  acc32_in_if.sink         in_if,
  acc32_out_if.source      out_if
);
  import acc32_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_OPER  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic              halt_r, halt_nxt;
  logic [DATA_W-1:0] ir_r, ir_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_acc_r, out_acc_nxt;
  logic [ADDR_W-1:0] out_pc_r, out_pc_nxt;
  logic              out_halt_r, out_halt_nxt;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Shared incrementer/decrementer.
  logic [DATA_W-1:0] add_a, add_b, add_sum;

  logic              in_fire;
  logic              out_free;
  opcode_t           ir_opc;
  logic [ADDR_W-1:0] ir_addr;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign ir_opc   = opcode_t'(ir_r[DATA_W-1:ADDR_W]);
  assign ir_addr  = ir_r[ADDR_W-1:0];

  assign in_if.ready      = (state_r == ST_IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.acc_value = out_acc_r;
  assign out_if.next_pc   = out_pc_r;
  assign out_if.halted    = out_halt_r;

  acc32_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The adder advances the program counter during fetch and moves the
  // accumulator by one during execute.
  always_comb begin
    if (state_r == ST_FETCH) begin
      add_a = {{(DATA_W-ADDR_W){1'b0}}, pc_r};
      add_b = {{(DATA_W-1){1'b0}}, 1'b1};
    end else begin
      add_a = acc_r;
      add_b = (ir_opc == OPC_DEC) ? {DATA_W{1'b1}} : {{(DATA_W-1){1'b0}}, 1'b1};
    end
    add_sum = add_a + add_b;
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    pc_nxt        = pc_r;
    halt_nxt      = halt_r;
    ir_nxt        = ir_r;
    out_valid_nxt = out_valid_r;
    out_acc_nxt   = out_acc_r;
    out_pc_nxt    = out_pc_r;
    out_halt_nxt  = out_halt_r;
    ram_we        = 1'b0;
    ram_waddr     = in_if.addr;
    ram_wdata     = in_if.data;
    ram_raddr     = pc_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // The read at pc is issued here so the word is ready in fetch.
        if (in_fire) begin
          state_nxt = ST_DONE;
          case (in_if.op)
            OP_LOADMEM: begin
              ram_we = 1'b1;
            end
            OP_RESTART: begin
              acc_nxt  = '0;
              pc_nxt   = '0;
              halt_nxt = 1'b0;
            end
            OP_STEP: begin
              if (!halt_r) begin
                state_nxt = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        ir_nxt    = ram_rdata;
        pc_nxt    = add_sum[ADDR_W-1:0];
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        ram_raddr = ir_addr;
        ram_waddr = ir_addr;
        ram_wdata = acc_r;
        case (ir_opc)
          OPC_STORE: ram_we = 1'b1;
          OPC_LOAD:  state_nxt = ST_OPER;
          OPC_BRZ: begin
            if (acc_r == '0) begin
              pc_nxt = ir_addr;
            end
          end
          OPC_NOP:   ;
          OPC_DEC:   acc_nxt = add_sum;
          OPC_INC:   acc_nxt = add_sum;
          OPC_JUMP:  pc_nxt = ir_addr;
          OPC_HALT:  halt_nxt = 1'b1;
          default:   ;
        endcase
      end
      ST_OPER: begin
        acc_nxt   = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Wait for the output register to drain before reporting.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc_r;
          out_pc_nxt    = pc_r;
          out_halt_nxt  = halt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ir_r       <= ir_nxt;
    out_acc_r  <= out_acc_nxt;
    out_pc_r   <= out_pc_nxt;
    out_halt_r <= out_halt_nxt;
  end

endmodule
